@@ rtl/tbp_pkg.sv @@
// Shared constants, types and counter functions for the tournament branch predictor.
package tbp_pkg;

	// Table geometry and counter widths
	localparam int PC_BITS            = 64;
	localparam int BIMODAL_INDEX_BITS = 12;
	localparam int GSHARE_INDEX_BITS  = 12;
	localparam int HISTORY_BITS       = 8;
	localparam int COUNTER_BITS       = 2;
	localparam int CHOOSER_BITS       = 2;

	localparam int BIMODAL_DEPTH = 2 ** BIMODAL_INDEX_BITS;
	localparam int GSHARE_DEPTH  = 2 ** GSHARE_INDEX_BITS;

	// Clear sequencer walks the deeper of the two tables
	localparam int CLEAR_BITS = (BIMODAL_INDEX_BITS > GSHARE_INDEX_BITS) ?
		BIMODAL_INDEX_BITS : GSHARE_INDEX_BITS;

	// Result queue
	localparam int RES_DEPTH      = 3;
	localparam int RES_PTR_BITS   = $clog2(RES_DEPTH);
	localparam int RES_COUNT_BITS = $clog2(RES_DEPTH + 1);

	typedef logic [PC_BITS-1:0]            pc_t;
	typedef logic [COUNTER_BITS-1:0]       ctr_t;
	typedef logic [CHOOSER_BITS-1:0]       chooser_t;
	typedef logic [HISTORY_BITS-1:0]       hist_t;
	typedef logic [BIMODAL_INDEX_BITS-1:0] bim_idx_t;
	typedef logic [GSHARE_INDEX_BITS-1:0]  gsh_idx_t;
	typedef logic [CLEAR_BITS-1:0]         clr_idx_t;
	typedef logic [RES_COUNT_BITS-1:0]     res_count_t;

	localparam ctr_t     CTR_HALF     = COUNTER_BITS'(2 ** (COUNTER_BITS - 1));
	localparam ctr_t     CTR_MAX      = {COUNTER_BITS{1'b1}};
	localparam chooser_t CHOOSER_HALF = CHOOSER_BITS'(2 ** (CHOOSER_BITS - 1));
	localparam chooser_t CHOOSER_MAX  = {CHOOSER_BITS{1'b1}};
	localparam clr_idx_t CLEAR_LAST   = {CLEAR_BITS{1'b1}};

	typedef struct packed {
		logic predicted_taken;
		logic used_gshare;
	} result_t;

	// Saturating step of a table counter toward the outcome
	function automatic ctr_t ctr_train(ctr_t v, logic up);
		ctr_t r;
		r = v;
		if (up && (v != CTR_MAX)) begin
			r = v + ctr_t'(1);
		end else if (!up && (v != '0)) begin
			r = v - ctr_t'(1);
		end
		return r;
	endfunction

	// Move the chooser toward whichever component alone was right
	function automatic chooser_t chooser_train(chooser_t c, logic bim_ok, logic gsh_ok);
		chooser_t r;
		r = c;
		if (bim_ok && !gsh_ok && (c != '0)) begin
			r = c - chooser_t'(1);
		end else if (!bim_ok && gsh_ok && (c != CHOOSER_MAX)) begin
			r = c + chooser_t'(1);
		end
		return r;
	endfunction

	// Gshare index: low index bits of pc XOR history
	function automatic gsh_idx_t gshare_index(pc_t pc, hist_t h);
		pc_t hx;
		hx = PC_BITS'(h);
		return pc[GSHARE_INDEX_BITS-1:0] ^ hx[GSHARE_INDEX_BITS-1:0];
	endfunction

endpackage

@@ rtl/tbp_table_ram.sv @@
// Single-clock counter table RAM: one write port, one registered read port.
module tbp_table_ram #(
	parameter int ADDR_BITS = 12,
	parameter int DATA_BITS = 2
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [2 ** ADDR_BITS];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/tbp_result_fifo.sv @@
// Small result queue between the training stage and the prediction output.
module tbp_result_fifo
	import tbp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  result_t    push_word,
	input  logic       pop,
	output logic       not_empty,
	output result_t    head_word,
	output res_count_t count
);

	result_t                 entries [RES_DEPTH];
	logic [RES_PTR_BITS-1:0] rd_ptr_q;
	logic [RES_PTR_BITS-1:0] wr_ptr_q;
	res_count_t              count_q;

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_word;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == RES_PTR_BITS'(RES_DEPTH - 1)) ? '0 :
					wr_ptr_q + RES_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == RES_PTR_BITS'(RES_DEPTH - 1)) ? '0 :
					rd_ptr_q + RES_PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + res_count_t'(1);
			end else if (!push && pop) begin
				count_q <= count_q - res_count_t'(1);
			end
		end
	end

	assign not_empty = (count_q != '0);
	assign head_word = entries[rd_ptr_q];
	assign count     = count_q;

	// Queue must never overflow or underflow
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != res_count_t'(RES_DEPTH)) || pop)
		else $error("result queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("result queue underflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= res_count_t'(RES_DEPTH))
		else $error("result queue count out of range");

endmodule

@@ rtl/tournament_branch_predictor.sv @@
// Tournament branch predictor top level: bimodal and gshare tables with a global chooser.
// Takes one resolved branch per cycle while branch_ready is high and returns, for each,
// the prediction made before training plus which component the chooser picked. The two
// counter tables live in synchronous RAMs: a branch reads both on the edge it is accepted
// and trains them on the next edge, with the last written entry forwarded so back-to-back
// branches to the same entry see fresh counters. The result passes through the stage-1
// register into a three-word queue, so one branch per cycle is sustained while the
// consumer keeps up. After reset the block clears both tables to weakly taken, one entry
// per cycle over all 2**12 = 4096 entries; branch_ready stays low until that pass is done.
module tournament_branch_predictor
	import tbp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic branch_valid,
	output logic branch_ready,
	input  pc_t  pc,
	input  logic taken,
	output logic pred_valid,
	input  logic pred_ready,
	output logic predicted_taken,
	output logic used_gshare
);

	logic       clearing_q;
	clr_idx_t   clr_q;
	hist_t      hist_q;
	chooser_t   chooser_q;

	logic       valid_s1;
	bim_idx_t   bim_idx_s1;
	gsh_idx_t   gsh_idx_s1;
	logic       taken_s1;

	logic       bim_fwd_q;
	bim_idx_t   bim_fwd_idx_q;
	ctr_t       bim_fwd_ctr_q;
	logic       gsh_fwd_q;
	gsh_idx_t   gsh_fwd_idx_q;
	ctr_t       gsh_fwd_ctr_q;

	logic       accept;
	bim_idx_t   bim_idx;
	gsh_idx_t   gsh_idx;
	ctr_t       bim_rdata;
	ctr_t       gsh_rdata;
	ctr_t       bim_ctr;
	ctr_t       gsh_ctr;
	ctr_t       bim_new;
	ctr_t       gsh_new;
	logic       bim_pred;
	logic       gsh_pred;
	logic       use_g;
	result_t    res_word;
	result_t    head_word;
	res_count_t res_count;
	logic       pop;

	logic       bim_we;
	bim_idx_t   bim_waddr;
	ctr_t       bim_wdata;
	logic       gsh_we;
	gsh_idx_t   gsh_waddr;
	ctr_t       gsh_wdata;

	// Accept a word only after the clear pass and when the queue has room for every result in flight
	assign branch_ready = !clearing_q &&
		((int'(res_count) + int'(valid_s1)) < RES_DEPTH);
	assign accept  = branch_valid && branch_ready;
	assign bim_idx = pc[BIMODAL_INDEX_BITS-1:0];
	assign gsh_idx = gshare_index(pc, hist_q);

	// Clear sequencer, then history update on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
			hist_q     <= '0;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + clr_idx_t'(1);
				if (clr_q == CLEAR_LAST) begin
					clearing_q <= 1'b0;
				end
			end
			if (accept) begin
				hist_q <= hist_t'({hist_q, taken});
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			bim_fwd_q <= 1'b0;
			gsh_fwd_q <= 1'b0;
		end else begin
			valid_s1  <= accept;
			bim_fwd_q <= valid_s1;
			gsh_fwd_q <= valid_s1;
		end
	end

	// Stage 1 payload and forwarding copies of the last write
	always_ff @(posedge clk) begin
		if (accept) begin
			bim_idx_s1 <= bim_idx;
			gsh_idx_s1 <= gsh_idx;
			taken_s1   <= taken;
		end
		if (valid_s1) begin
			bim_fwd_idx_q <= bim_idx_s1;
			bim_fwd_ctr_q <= bim_new;
			gsh_fwd_idx_q <= gsh_idx_s1;
			gsh_fwd_ctr_q <= gsh_new;
		end
	end

	// Pick fresh counters, predict, and train
	always_comb begin
		bim_ctr  = (bim_fwd_q && (bim_fwd_idx_q == bim_idx_s1)) ? bim_fwd_ctr_q : bim_rdata;
		gsh_ctr  = (gsh_fwd_q && (gsh_fwd_idx_q == gsh_idx_s1)) ? gsh_fwd_ctr_q : gsh_rdata;
		bim_pred = bim_ctr[COUNTER_BITS-1];
		gsh_pred = gsh_ctr[COUNTER_BITS-1];
		use_g    = chooser_q[CHOOSER_BITS-1];
		bim_new  = ctr_train(bim_ctr, taken_s1);
		gsh_new  = ctr_train(gsh_ctr, taken_s1);
		res_word.predicted_taken = use_g ? gsh_pred : bim_pred;
		res_word.used_gshare     = use_g;
	end

	// Chooser update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chooser_q <= CHOOSER_HALF;
		end else if (valid_s1) begin
			chooser_q <= chooser_train(chooser_q, bim_pred == taken_s1, gsh_pred == taken_s1);
		end
	end

	// Write ports: clear pass first, training writes after
	always_comb begin
		if (clearing_q) begin
			bim_we    = int'(clr_q) < BIMODAL_DEPTH;
			bim_waddr = clr_q[BIMODAL_INDEX_BITS-1:0];
			bim_wdata = CTR_HALF;
			gsh_we    = int'(clr_q) < GSHARE_DEPTH;
			gsh_waddr = clr_q[GSHARE_INDEX_BITS-1:0];
			gsh_wdata = CTR_HALF;
		end else begin
			bim_we    = valid_s1;
			bim_waddr = bim_idx_s1;
			bim_wdata = bim_new;
			gsh_we    = valid_s1;
			gsh_waddr = gsh_idx_s1;
			gsh_wdata = gsh_new;
		end
	end

	tbp_table_ram #(
		.ADDR_BITS (BIMODAL_INDEX_BITS),
		.DATA_BITS (COUNTER_BITS)
	) u_bim_ram (
		.clk   (clk),
		.we    (bim_we),
		.waddr (bim_waddr),
		.wdata (bim_wdata),
		.re    (accept),
		.raddr (bim_idx),
		.rdata (bim_rdata)
	);

	tbp_table_ram #(
		.ADDR_BITS (GSHARE_INDEX_BITS),
		.DATA_BITS (COUNTER_BITS)
	) u_gsh_ram (
		.clk   (clk),
		.we    (gsh_we),
		.waddr (gsh_waddr),
		.wdata (gsh_wdata),
		.re    (accept),
		.raddr (gsh_idx),
		.rdata (gsh_rdata)
	);

	assign pop = pred_valid && pred_ready;

	tbp_result_fifo u_result_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_word (res_word),
		.pop       (pop),
		.not_empty (pred_valid),
		.head_word (head_word),
		.count     (res_count)
	);

	assign predicted_taken = head_word.predicted_taken;
	assign used_gshare     = head_word.used_gshare;

	// No training write may overlap the clear pass
	a_no_train_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !valid_s1)
		else $error("training write during table clear");

	// Chooser moves only on the cycle after a word was in stage 1
	a_chooser_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(chooser_q != $past(chooser_q)) |-> $past(valid_s1))
		else $error("chooser changed without a trained branch");

	// Clear pass ends only after the last entry
	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> $past(clr_q) == CLEAR_LAST)
		else $error("table clear ended early");

	// Results in flight never exceed queue room
	a_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(res_count) + int'(valid_s1)) <= RES_DEPTH)
		else $error("more results in flight than queue room");

endmodule
